>>> hw/rtl/dcb_pkg.sv
// ============================================================================
// dcb_pkg: shared types and constants of the de Casteljau evaluator
//
// Command codes, configuration register indexes, field widths and the state
// type of the evaluation sequencer.
// ============================================================================
package dcb_pkg;

    // Request kinds carried on the input channel's tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_INTER  = 1'b1;
    localparam int CFG_DATA_W = 4;

    // Register reset values.
    localparam logic [3:0] POINT_COUNT_RST = 4'd5;
    localparam logic       EMIT_INTER_RST  = 1'b0;

    // Field widths.
    localparam int COORD_W  = 16;   // control point coordinate, integer units
    localparam int FIX_W    = 24;   // Q16.8 point coordinate
    localparam int PARAM_W  = 17;   // t in Q1.16
    localparam int SLOT_W   = 3;    // point_index
    localparam int LEVEL_W  = 3;    // reduction level on the output
    localparam int FRAC_SH  = 16;   // fraction bits of t
    localparam int DIFF_W   = FIX_W + 1;
    localparam int PROD_W   = DIFF_W + PARAM_W + 1;

    // Parameter value of exactly one.
    localparam logic [PARAM_W-1:0] T_ONE = 17'h10000;

    // Packed channel widths.
    localparam int S_TDATA_W = 56;  // 52 bits of fields, padded to bytes
    localparam int M_TDATA_W = 48;

    // Evaluation sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } dcb_state_t;

endpackage

>>> hw/rtl/de_casteljau_bezier_eval_unit.sv
// ============================================================================
// de_casteljau_bezier_eval_unit: 2D Bezier curve evaluator
//
// Reduces up to MAX_POINTS control points by repeated linear interpolation
// out of a control point RAM and a working point RAM.
// ============================================================================
// Usage:
//   The input channel (s_*) takes two kinds of request, selected by s_tuser.
//   A load writes one control point into its slot and gives no result. An
//   evaluate reduces the first point_count points at parameter t and gives
//   either the curve point alone or every intermediate point in order, the
//   last of them flagged by m_tlast. The config channel (cfg_*) writes
//   point_count (index 0) and emit_intermediates (index 1); the user must
//   write them only while idle, as the block itself does not enforce it.
//   An evaluate over n points streams one interpolation per cycle out of
//   the working RAM while m_tready does not stall it; the registered RAM
//   read sets the pace. The block takes the next request once the
//   evaluation has left its pipeline, even while the final result still
//   waits in the output register. A load leaves the block ready.
//   Reset empties the pipeline, marks all control points as zero and sets
//   point_count to 5 and emit_intermediates to 0. While the receiver holds
//   m_tready low with a result pending, the whole interpolation pipeline and
//   the RAM read ports stop and resume without loss.
// ============================================================================
module de_casteljau_bezier_eval_unit
    import dcb_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input requests.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_index[2:0], point_x[18:3], point_y[34:19], curve_param[51:35]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic                  s_tuser,
    // Results.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // curve_x[23:0], curve_y[47:24]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // level[2:0]
    output logic [LEVEL_W-1:0]    m_tuser,
    output logic                  m_tlast,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // Input field unpacking.
    logic [SLOT_W-1:0]  in_slot;
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [PARAM_W-1:0] in_param;

    assign in_slot  = s_tdata[2:0];
    assign in_x     = s_tdata[18:3];
    assign in_y     = s_tdata[34:19];
    assign in_param = s_tdata[51:35];

    // Control and configuration registers.
    dcb_state_t        state_reg, state_next;
    logic [3:0]        point_count_reg;
    logic              emit_reg;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [PARAM_W-1:0] t_reg, t_next;
    logic              single_reg, single_next;
    logic [IDX_W-1:0]  lvl_reg, lvl_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [MAX_POINTS-1:0] ctrl_vld_reg;

    // Read stage tags, aligned with the RAM read data.
    logic              rv_reg;
    logic              rfirst_reg;
    logic              rsrc_reg;
    logic              rpass_reg;
    logic              rlast_reg;
    logic              remit_reg;
    logic              rvld_reg;
    logic [IDX_W-1:0]  rlvl_reg;
    logic [IDX_W-1:0]  ridx_reg;
    logic              fwd_reg;
    logic [2*FIX_W-1:0] fwd_data_reg;

    // Interpolation stage.
    logic signed [FIX_W-1:0]  a_x_reg, a_y_reg;
    logic                     dv_reg;
    logic                     wlast_reg, wemit_reg;
    logic [IDX_W-1:0]         wlvl_reg, widx_reg;
    logic signed [FIX_W-1:0]  ahold_x_reg, ahold_y_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;

    // Output register.
    logic                    m_valid_reg;
    logic [FIX_W-1:0]        m_x_reg, m_y_reg;
    logic [LEVEL_W-1:0]      m_lvl_reg;
    logic                    m_last_reg;

    // Handshakes and pipeline advance.
    logic s_acc, is_eval, is_load, adv, out_load;
    logic issue;
    logic [CNT_W-1:0] len;
    logic last_level;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign is_eval   = s_acc && (s_tuser == CMD_EVAL);
    assign is_load   = s_acc && (s_tuser == CMD_LOAD);
    assign adv       = !(m_valid_reg && !m_tready);

    // RAM ports.
    logic                   ctrl_we;
    logic [2*COORD_W-1:0]   ctrl_rdata;
    logic                   work_we;
    logic [2*FIX_W-1:0]     work_wdata, work_rdata;

    assign ctrl_we = is_load && (int'(in_slot) < MAX_POINTS);

    dcb_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_ctrl_ram (
        .aclk  (aclk),
        .we    (ctrl_we),
        .waddr (in_slot[IDX_W-1:0]),
        .wdata ({in_y, in_x}),
        .re    (adv),
        .raddr (idx_reg),
        .rdata (ctrl_rdata)
    );

    dcb_ram #(
        .WIDTH (2 * FIX_W),
        .DEPTH (MAX_POINTS)
    ) u_work_ram (
        .aclk  (aclk),
        .we    (work_we),
        .waddr (widx_reg),
        .wdata (work_wdata),
        .re    (adv),
        .raddr (idx_reg),
        .rdata (work_rdata)
    );

    // Configuration registers and control point valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= POINT_COUNT_RST;
            emit_reg        <= EMIT_INTER_RST;
            ctrl_vld_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_POINT_COUNT: point_count_reg <= cfg_data;
                    CFG_EMIT_INTER:  emit_reg        <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (ctrl_we) begin
                ctrl_vld_reg[in_slot[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // Sequencer: walks levels and read indexes, one read per advancing cycle.
    assign len        = n_reg - CNT_W'(lvl_reg);
    assign last_level = (CNT_W'(lvl_reg) == n_reg - CNT_W'(1));

    always_comb begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        t_next      = t_reg;
        single_next = single_reg;
        issue       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (is_eval) begin
                    state_next = ST_RUN;
                    lvl_next   = IDX_W'(1);
                    idx_next   = '0;
                    t_next     = (in_param > T_ONE) ? T_ONE : in_param;
                    if (point_count_reg <= 4'd1) begin
                        n_next = CNT_W'(1);
                    end else if (int'(point_count_reg) > MAX_POINTS) begin
                        n_next = CNT_W'(MAX_POINTS);
                    end else begin
                        n_next = CNT_W'(point_count_reg);
                    end
                    single_next = (point_count_reg <= 4'd1);
                end
            end
            ST_RUN: begin
                if (adv) begin
                    issue = 1'b1;
                    if (single_reg) begin
                        state_next = ST_DRAIN;
                    end else if (CNT_W'(idx_reg) == len) begin
                        if (last_level) begin
                            state_next = ST_DRAIN;
                        end else begin
                            lvl_next = lvl_reg + IDX_W'(1);
                            idx_next = '0;
                        end
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!rv_reg && !dv_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg    <= lvl_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        t_reg      <= t_next;
        single_reg <= single_next;
    end

    // Read stage: tags travel with the request into the RAM read register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
        end else if (adv) begin
            rv_reg <= issue;
        end
    end

    // A short level ends while the next one already reads its first points,
    // so a working point written at the same edge as its read is forwarded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (adv) begin
            fwd_reg <= work_we && (widx_reg == idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rfirst_reg   <= (idx_reg == '0) && !single_reg;
            rsrc_reg     <= (lvl_reg == IDX_W'(1));
            rpass_reg    <= single_reg;
            rlast_reg    <= single_reg || last_level;
            remit_reg    <= single_reg || last_level || emit_reg;
            rvld_reg     <= ctrl_vld_reg[idx_reg];
            rlvl_reg     <= single_reg ? '0 : lvl_reg;
            ridx_reg     <= idx_reg;
            fwd_data_reg <= work_wdata;
        end
    end

    // Interpolation stage: B - A times t, one multiplier per coordinate.
    logic signed [FIX_W-1:0]    b_x, b_y;
    logic signed [DIFF_W-1:0]   diff_x, diff_y;
    logic signed [PARAM_W:0]    t_s;
    logic signed [PROD_W-1:0]   mul_x, mul_y;

    always_comb begin
        if (rsrc_reg) begin
            // A control point that was never loaded reads as zero.
            b_x = rvld_reg ? {ctrl_rdata[COORD_W-1:0], 8'h00} : '0;
            b_y = rvld_reg ? {ctrl_rdata[2*COORD_W-1:COORD_W], 8'h00} : '0;
        end else if (fwd_reg) begin
            b_x = fwd_data_reg[FIX_W-1:0];
            b_y = fwd_data_reg[2*FIX_W-1:FIX_W];
        end else begin
            b_x = work_rdata[FIX_W-1:0];
            b_y = work_rdata[2*FIX_W-1:FIX_W];
        end
    end

    assign diff_x = DIFF_W'(b_x) - DIFF_W'(a_x_reg);
    assign diff_y = DIFF_W'(b_y) - DIFF_W'(a_y_reg);
    assign t_s    = $signed({1'b0, t_reg});
    assign mul_x  = diff_x * t_s;
    assign mul_y  = diff_y * t_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
        end else if (adv) begin
            dv_reg <= rv_reg && !rfirst_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && rv_reg) begin
            a_x_reg     <= b_x;
            a_y_reg     <= b_y;
            ahold_x_reg <= rpass_reg ? b_x : a_x_reg;
            ahold_y_reg <= rpass_reg ? b_y : a_y_reg;
            prod_x_reg  <= rpass_reg ? '0 : mul_x;
            prod_y_reg  <= rpass_reg ? '0 : mul_y;
            wlast_reg   <= rlast_reg;
            wemit_reg   <= remit_reg;
            wlvl_reg    <= rlvl_reg;
            widx_reg    <= rpass_reg ? '0 : ridx_reg - IDX_W'(1);
        end
    end

    // Write-back stage: floor shift of the product plus A, modulo 24 bits,
    // since the result always lies between A and B.
    logic [FIX_W-1:0] res_x, res_y;

    assign res_x      = ahold_x_reg + prod_x_reg[FRAC_SH+FIX_W-1:FRAC_SH];
    assign res_y      = ahold_y_reg + prod_y_reg[FRAC_SH+FIX_W-1:FRAC_SH];
    assign work_we    = dv_reg && adv;
    assign work_wdata = {res_y, res_x};
    assign out_load   = dv_reg && wemit_reg && adv;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_x_reg    <= res_x;
            m_y_reg    <= res_y;
            m_lvl_reg  <= LEVEL_W'(wlvl_reg);
            m_last_reg <= wlast_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_y_reg, m_x_reg};
    assign m_tuser  = m_lvl_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> hw/rtl/dcb_ram.sv
// ============================================================================
// dcb_ram: generic single-port-write, single-port-read RAM
//
// One write and one read per cycle; the read data is registered and held
// while the read enable is low.
// ============================================================================
module dcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/dcb_checker.sv
// ============================================================================
// dcb_checker: port-level checks of the de Casteljau evaluator
//
// Watches the request and result channels over time; attached to the top
// level by the bind statement at the end of this file.
// ============================================================================
module dcb_checker
    import dcb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [LEVEL_W-1:0]   m_tuser,
    input logic                 m_tlast
);

    // An evaluate request occupies the block for at least the next cycle.
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_EVAL) |=> !s_tready)
        else $error("request accepted in the cycle after an evaluate");

    // A load request leaves the block ready for the next one.
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> s_tready)
        else $error("block not ready after a load request");

    // Only intermediate points come without the last flag, never at level 0.
    a_inter_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tuser != '0))
        else $error("intermediate result at level zero");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind de_casteljau_bezier_eval_unit dcb_checker u_dcb_checker (.*);

>>> sim/tb_de_casteljau_bezier_eval_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_de_casteljau_bezier_eval_unit: testbench of the de Casteljau evaluator
//
// Loads control points and evaluates the curve under many point counts, with
// and without intermediate points. A local model of the interpolation works
// out every expected point. A monitor compares each result, field by field
// and in order, while both stream sides idle and stall at random.
// ============================================================================
module tb_de_casteljau_bezier_eval_unit;
    import dcb_pkg::*;

    localparam int CTRL_SLOTS     = 8;
    localparam int MAX_GAP        = 10;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 4000;

    // One request as the sender sees it.
    typedef struct {
        logic                      cmd;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [PARAM_W-1:0]        t;
    } bezier_req_t;

    // One expected curve or intermediate point.
    typedef struct {
        logic [FIX_W-1:0]   x;
        logic [FIX_W-1:0]   y;
        logic [LEVEL_W-1:0] lvl;
        logic               last;
    } curve_point_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [LEVEL_W-1:0]    m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bezier_req_t  req_backlog[$];
    curve_point_t expected_points[$];

    // Local copy of the block's control points and registers.
    logic signed [COORD_W-1:0] ctrl_x[CTRL_SLOTS] = '{default: '0};
    logic signed [COORD_W-1:0] ctrl_y[CTRL_SLOTS] = '{default: '0};
    logic [3:0]                cur_point_count   = POINT_COUNT_RST;
    logic                      cur_emit          = EMIT_INTER_RST;

    logic s_fire         = 1'b0;
    logic m_fire         = 1'b0;
    bit   sender_quiet   = 1'b0;
    bit   receiver_quiet = 1'b0;
    int   send_wait      = 0;
    int   recv_wait      = 0;
    int   hold_left      = 0;
    int   idle_run       = 0;
    int   errors         = 0;
    int   loads_taken    = 0;
    int   evals_taken    = 0;
    int   points_checked = 0;

    de_casteljau_bezier_eval_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // One interpolation step: a + floor((b - a) * t / 2^16).
    function automatic longint blend(longint a, longint b, longint t);
        longint prod;
        prod = (b - a) * t;
        return a + (prod >>> FRAC_SH);
    endfunction

    // Reduces the active control points and queues the points the block
    // is expected to return.
    function automatic void predict_curve(logic [PARAM_W-1:0] t_in);
        longint       wx[CTRL_SLOTS];
        longint       wy[CTRL_SLOTS];
        longint       t;
        int           n;
        int           produced;
        curve_point_t pt;
        n = cur_point_count;
        if (n < 1) n = 1;
        if (n > CTRL_SLOTS) n = CTRL_SLOTS;
        t = (t_in > T_ONE) ? T_ONE : t_in;
        for (int i = 0; i < n; i++) begin
            wx[i] = longint'(ctrl_x[i]) * 256;
            wy[i] = longint'(ctrl_y[i]) * 256;
        end
        produced = 0;
        for (int r = 1; r < n; r++) begin
            for (int i = 0; i + r < n; i++) begin
                wx[i] = blend(wx[i], wx[i + 1], t);
                wy[i] = blend(wy[i], wy[i + 1], t);
                if (cur_emit) begin
                    pt.x    = wx[i][FIX_W-1:0];
                    pt.y    = wy[i][FIX_W-1:0];
                    pt.lvl  = LEVEL_W'(r);
                    pt.last = (r == n - 1);
                    expected_points.push_back(pt);
                    produced++;
                end
            end
        end
        // Only the curve point, or a single control point.
        if (produced == 0) begin
            pt.x    = wx[0][FIX_W-1:0];
            pt.y    = wy[0][FIX_W-1:0];
            pt.lvl  = LEVEL_W'(n - 1);
            pt.last = 1'b1;
            expected_points.push_back(pt);
        end
    endfunction

    function automatic void check_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // Monitor: registers, accepted requests, results and the watchdog.
    always @(posedge aclk) begin : monitor
        curve_point_t head;
        s_fire <= aresetn && s_tvalid && s_tready;
        m_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_POINT_COUNT)
                    cur_point_count = cfg_data;
                else if (cfg_index == CFG_EMIT_INTER)
                    cur_emit = cfg_data[0];
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    ctrl_x[s_tdata[2:0]] = s_tdata[18:3];
                    ctrl_y[s_tdata[2:0]] = s_tdata[34:19];
                    loads_taken++;
                end else begin
                    predict_curve(s_tdata[51:35]);
                    evals_taken++;
                end
            end
            if (m_tvalid && m_tready) begin
                points_checked++;
                if (expected_points.size() == 0) begin
                    $error("Result with nothing expected: curve_x %0d, curve_y %0d",
                           $signed(m_tdata[FIX_W-1:0]), $signed(m_tdata[2*FIX_W-1:FIX_W]));
                    errors++;
                end else begin
                    head = expected_points.pop_front();
                    check_field("curve_x", $signed(head.x), $signed(m_tdata[FIX_W-1:0]));
                    check_field("curve_y", $signed(head.y),
                                $signed(m_tdata[2*FIX_W-1:FIX_W]));
                    check_field("level", head.lvl, m_tuser);
                    check_field("is_last", head.last, m_tlast);
                end
            end
            // Give up once nothing has moved for too long.
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles.", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Sender: presents queued requests with random gaps between them.
    always @(negedge aclk) begin : feeder
        bezier_req_t req;
        if (aresetn && !(s_tvalid && !s_fire)) begin
            if (send_wait > 0) begin
                s_tvalid <= 1'b0;
                send_wait--;
            end else if (req_backlog.size() > 0) begin
                req = req_backlog.pop_front();
                s_tuser  <= req.cmd;
                s_tdata  <= {4'b0000, req.t, req.py, req.px, req.slot};
                s_tvalid <= 1'b1;
                send_wait = draw_gap(sender_quiet);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each result, plus one long hold-off.
    always @(negedge aclk) begin : sink
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            if (m_fire)
                recv_wait = draw_gap(receiver_quiet);
            if (recv_wait > 0) begin
                m_tready <= 1'b0;
                recv_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Parameter values lean toward both ends and the saturated range.
    function automatic logic [PARAM_W-1:0] rand_param();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return T_ONE;
            2: return T_ONE - 1;
            3: return PARAM_W'($urandom_range(T_ONE + 1, 2**PARAM_W - 1));
            default: return PARAM_W'($urandom_range(0, T_ONE));
        endcase
    endfunction

    function automatic void queue_load(logic [SLOT_W-1:0] slot,
                                       logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y);
        bezier_req_t req;
        req.cmd  = CMD_LOAD;
        req.slot = slot;
        req.px   = x;
        req.py   = y;
        req.t    = PARAM_W'($urandom);
        req_backlog.push_back(req);
    endfunction

    function automatic void queue_eval(logic [PARAM_W-1:0] t);
        bezier_req_t req;
        req.cmd  = CMD_EVAL;
        req.slot = SLOT_W'($urandom);
        req.px   = COORD_W'($urandom);
        req.py   = COORD_W'($urandom);
        req.t    = t;
        req_backlog.push_back(req);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every request is taken and every point has come back.
    task automatic settle();
        while (req_backlog.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One setting of the registers followed by a batch of random requests.
    // A squeezed phase sends only evaluations into a long receiver stall.
    task automatic run_phase(int count, bit emit, int n_items, bit quiet, bit squeeze);
        write_reg(CFG_POINT_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_EMIT_INTER, {3'($urandom), emit});
        sender_quiet   = quiet;
        receiver_quiet = quiet;
        if (squeeze)
            hold_left = LONG_HOLD;
        repeat (n_items) begin
            if (!squeeze && $urandom_range(0, 99) < 35)
                queue_load(SLOT_W'($urandom), rand_coord(), rand_coord());
            else
                queue_eval(rand_param());
        end
        settle();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset setting: zero points first, then the
        // coordinate extremes and the notable parameter values.
        queue_eval('0);
        queue_load(3'd0, 16'sh8000, 16'sh7fff);
        queue_load(3'd1, 16'sh7fff, 16'sh8000);
        queue_load(3'd2, -16'sd1, 16'sd1);
        queue_load(3'd3, 16'sd1, -16'sd1);
        queue_load(3'd4, 16'sd0, 16'sd0);
        queue_load(3'd5, 16'sd12345, -16'sd23456);
        queue_load(3'd6, 16'sh8000, 16'sh8000);
        queue_load(3'd7, 16'sh7fff, 16'sh7fff);
        queue_eval('0);
        queue_eval(T_ONE);
        queue_eval(T_ONE >> 1);
        queue_eval(17'd1);
        queue_eval(T_ONE - 1);
        queue_eval(17'h1ffff);
        queue_eval(T_ONE + 1);
        settle();

        // Random part across point counts, including zero and values above
        // the number of slots, with both output modes.
        run_phase(1, 1'b1, 20, 1'b0, 1'b0);
        run_phase(8, 1'b1, 20, 1'b0, 1'b0);
        run_phase(0, 1'b0, 20, 1'b1, 1'b0);
        run_phase(15, 1'b1, 20, 1'b0, 1'b0);
        run_phase(8, 1'b0, 20, 1'b0, 1'b0);
        run_phase(2, 1'b1, 20, 1'b1, 1'b0);
        run_phase(8, 1'b1, 15, 1'b1, 1'b1);
        run_phase(3, 1'b0, 20, 1'b0, 1'b0);
        run_phase(6, 1'b1, 20, 1'b0, 1'b0);
        run_phase(7, 1'b0, 15, 1'b1, 1'b0);
        run_phase(4, 1'b1, 15, 1'b0, 1'b0);
        run_phase($urandom_range(0, 15), 1'($urandom), 15, 1'b0, 1'b0);

        $display("Run covered %0d loads and %0d evaluations, %0d points compared.",
                 loads_taken, evals_taken, points_checked);
        $display("Point counts 0 to 15, both output modes and one long output stall.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/dcb_pkg.sv
hw/rtl/dcb_ram.sv
hw/rtl/de_casteljau_bezier_eval_unit.sv
hw/rtl/dcb_checker.sv
sim/tb_de_casteljau_bezier_eval_unit.sv
